[rtl/core/naf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_pkg
// Shared types and codes of the neighbor aware FIFO arbiter.
// ----------------------------------------------------------------------------
package naf_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

endpackage

[rtl/core/neighbor_aware_fifo_arbiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_aware_fifo_arbiter
// Ordered queue of requester ids; grants a request when no neighbor id is
// queued ahead of the requester, and removes ids on release.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         tuser: action; tdata: requester, left, right ids
// m_*       out        tdata: granted, status, queue count
//
// A transfer is taken only in the idle state. The queue is scanned one entry
// per cycle through the registered read port of the queue RAM. A request of a
// queued id stops the scan at its position; an absent id is scanned to the end.
// A release of a queued id then moves each later entry down by one, one per
// cycle. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module neighbor_aware_fifo_arbiter #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // requester_id, left_neighbor_id, right_neighbor_id
    input  logic [((3*ID_BITS+7)/8)*8-1:0]              s_tdata,
    // action
    input  logic                                        s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // granted, status, queue_count
    output logic [((3+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               nbr_reg, nbr_next;
    logic               granted_reg, granted_next;
    naf_pkg::status_t   status_reg, status_next;
    logic               action_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] left_reg;
    logic [ID_BITS-1:0] right_reg;

    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ID_BITS-1:0] ram_wr_data;
    logic [ID_BITS-1:0] ram_rd_data;

    logic               issue;
    logic               entry_hit;
    logic               entry_nbr;
    logic               nbr_all;
    logic               self_nbr;
    logic [CNT_W-1:0]   shift_dst;

    naf_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_RESP);

    assign issue     = (scan_idx_reg < cnt_reg);
    assign entry_hit = chk_valid_reg && (ram_rd_data == id_reg);
    assign entry_nbr = chk_valid_reg && ((ram_rd_data == left_reg) ||
                                         (ram_rd_data == right_reg));
    assign nbr_all   = nbr_reg | entry_nbr;
    assign self_nbr  = (id_reg == left_reg) || (id_reg == right_reg);
    assign shift_dst = chk_idx_reg - CNT_W'(1);

    always_comb begin
        m_tdata            = '0;
        m_tdata[0]         = granted_reg;
        m_tdata[2:1]       = status_reg;
        m_tdata[3 +: CNT_W] = cnt_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = scan_idx_reg;
        chk_valid_next = 1'b0;
        nbr_next       = nbr_reg;
        granted_next   = granted_reg;
        status_next    = status_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cnt_reg[IDX_W-1:0];
        ram_wr_data    = id_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    scan_idx_next = '0;
                    nbr_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                nbr_next       = nbr_all;
                chk_valid_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (entry_hit) begin
                    if (action_reg == naf_pkg::ACT_REQUEST) begin
                        granted_next = !nbr_all;
                        status_next  = naf_pkg::STATUS_OK;
                        state_next   = ST_RESP;
                    end else begin
                        scan_idx_next  = chk_idx_reg + CNT_W'(1);
                        chk_valid_next = 1'b0;
                        state_next     = ST_SHIFT;
                    end
                end else if (!issue) begin
                    state_next = ST_RESP;
                    if (action_reg == naf_pkg::ACT_REQUEST) begin
                        if (cnt_reg < CNT_W'(QUEUE_DEPTH)) begin
                            ram_wr_en    = 1'b1;
                            cnt_next     = cnt_reg + CNT_W'(1);
                            granted_next = !(nbr_all || self_nbr);
                            status_next  = naf_pkg::STATUS_OK;
                        end else begin
                            granted_next = 1'b0;
                            status_next  = naf_pkg::STATUS_FULL;
                        end
                    end else begin
                        granted_next = 1'b0;
                        status_next  = naf_pkg::STATUS_NOT_FOUND;
                    end
                end
            end
            ST_SHIFT: begin
                chk_valid_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = shift_dst[IDX_W-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (!issue) begin
                    cnt_next     = cnt_reg - CNT_W'(1);
                    granted_next = 1'b0;
                    status_next  = naf_pkg::STATUS_OK;
                    state_next   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        nbr_reg      <= nbr_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            id_reg     <= s_tdata[0 +: ID_BITS];
            left_reg   <= s_tdata[ID_BITS +: ID_BITS];
            right_reg  <= s_tdata[2*ID_BITS +: ID_BITS];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds the queue depth.");

    a_full_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_reg == naf_pkg::STATUS_FULL))
            |-> (cnt_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("Full status reported while the queue has room.");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && granted_reg) |-> (status_reg == naf_pkg::STATUS_OK))
        else $error("Grant reported together with an error status.");

    a_release_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SHIFT) && !issue) |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("Release did not remove exactly one entry.");

endmodule

[rtl/core/naf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module naf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[tb/neighbor_aware_fifo_arbiter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_aware_fifo_arbiter_test
// Self-checking bench for the neighbor aware FIFO arbiter. A directed run
// covers the empty and full queue, repeated and self-neighbor requests and
// releases at the head, the middle and of absent ids. Random request and
// release traffic over small id pools follows, in three phases with
// different stall patterns. Every result is checked against a queue model
// kept in the bench.
// ----------------------------------------------------------------------------
module neighbor_aware_fifo_arbiter_test;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int POOL_SIZE   = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic       action;
        logic [7:0] id;
        logic [7:0] left;
        logic [7:0] right;
    } arb_item_t;

    typedef struct {
        logic             granted;
        naf_pkg::status_t status;
        logic [4:0]       count;
    } arb_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    arb_item_t   pending_items[$];
    arb_result_t expected_results[$];
    logic [7:0]  queued_ids[$];
    logic [7:0]  id_pool[POOL_SIZE];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   accepted_items;
    int   total_items;
    int   err_count;
    int   cycle_count;
    logic in_taken;

    neighbor_aware_fifo_arbiter #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic arb_result_t arbitrate(arb_item_t item);
        arb_result_t r;
        int pos;
        r.granted = 1'b0;
        r.status  = naf_pkg::STATUS_OK;
        pos = -1;
        foreach (queued_ids[i]) begin
            if (pos < 0 && queued_ids[i] == item.id) pos = i;
        end
        if (item.action == naf_pkg::ACT_REQUEST) begin
            if (pos < 0) begin
                if (queued_ids.size() >= QUEUE_DEPTH) r.status = naf_pkg::STATUS_FULL;
                else queued_ids.push_back(item.id);
            end
            if (r.status == naf_pkg::STATUS_OK) begin
                r.granted = 1'b1;
                // A neighbor match counts before the self match at each place.
                for (int i = 0; i < queued_ids.size(); i++) begin
                    if (queued_ids[i] == item.left || queued_ids[i] == item.right) begin
                        r.granted = 1'b0;
                        break;
                    end
                    if (queued_ids[i] == item.id) break;
                end
            end
        end else begin
            if (pos < 0) r.status = naf_pkg::STATUS_NOT_FOUND;
            else queued_ids.delete(pos);
        end
        r.count = 5'(queued_ids.size());
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic add_item(logic action, logic [7:0] id, logic [7:0] left,
                            logic [7:0] right);
        arb_item_t item;
        item.action = action;
        item.id     = id;
        item.left   = left;
        item.right  = right;
        pending_items.push_back(item);
        total_items++;
    endtask

    function automatic logic [7:0] pick_neighbor(logic [7:0] id);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 9) return 8'($urandom);
        else return id;
    endfunction

    task automatic add_random(int req_pct);
        logic       action;
        logic [7:0] id;
        action = ($urandom_range(0, 99) < req_pct) ? naf_pkg::ACT_REQUEST
                                                   : naf_pkg::ACT_RELEASE;
        if ($urandom_range(0, 19) == 0) id = 8'($urandom);
        else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        add_item(action, id, pick_neighbor(id), pick_neighbor(id));
    endtask

    task automatic wait_drained();
        while ((accepted_items < total_items || expected_results.size() > 0) &&
               cycle_count < CYCLE_LIMIT)
            @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        arb_result_t want;
        arb_item_t   seen;
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result transfer, tdata %h", m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.granted || m_tdata[2:1] !== want.status ||
                    m_tdata[7:3] !== want.count)
                    report_mismatch($sformatf(
                        "granted %b status %0d count %0d, expected %b %0d %0d",
                        m_tdata[0], m_tdata[2:1], m_tdata[7:3],
                        want.granted, want.status, want.count));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            seen.action = s_tuser;
            seen.id     = s_tdata[7:0];
            seen.left   = s_tdata[15:8];
            seen.right  = s_tdata[23:16];
            expected_results.push_back(arbitrate(seen));
            accepted_items++;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        arb_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {item.right, item.left, item.id};
                s_tuser  <= item.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        int req_pct[3];
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = naf_pkg::ACT_REQUEST;
        m_tready       = 1'b0;
        in_taken       = 1'b0;
        accepted_items = 0;
        total_items    = 0;
        err_count      = 0;
        cycle_count    = 0;
        send_idle_pct  = 14;
        recv_idle_pct  = 55;
        req_pct[0] = 60;
        req_pct[1] = 80;
        req_pct[2] = 35;

        add_item(naf_pkg::ACT_RELEASE, 8'h00, 8'h00, 8'h00);
        add_item(naf_pkg::ACT_REQUEST, 8'h00, 8'hFF, 8'hFF);
        add_item(naf_pkg::ACT_REQUEST, 8'hFF, 8'h00, 8'h01);
        add_item(naf_pkg::ACT_REQUEST, 8'hFF, 8'h12, 8'h34);
        add_item(naf_pkg::ACT_REQUEST, 8'h55, 8'h55, 8'hAA);
        for (int i = 1; i <= 13; i++)
            add_item(naf_pkg::ACT_REQUEST, 8'(i), 8'($urandom), 8'($urandom));
        add_item(naf_pkg::ACT_REQUEST, 8'hEE, 8'h01, 8'h02);
        add_item(naf_pkg::ACT_REQUEST, 8'h03, 8'hFE, 8'h7F);
        add_item(naf_pkg::ACT_RELEASE, 8'h55, 8'hFF, 8'h00);
        add_item(naf_pkg::ACT_RELEASE, 8'h00, 8'h00, 8'hFF);
        add_item(naf_pkg::ACT_RELEASE, 8'hFF, 8'hAA, 8'h55);
        add_item(naf_pkg::ACT_RELEASE, 8'h77, 8'h00, 8'h00);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 55;
                recv_idle_pct = 14;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            foreach (id_pool[i]) id_pool[i] = 8'($urandom);
            repeat (233) add_random(req_pct[phase]);
            wait_drained();
        end

        repeat (50) @(negedge aclk);
        if (cycle_count < CYCLE_LIMIT && err_count == 0 && expected_results.size() == 0) begin
            $display("neighbor_aware_fifo_arbiter test passed");
        end else begin
            $display("neighbor_aware_fifo_arbiter test failed");
        end
        $finish;
    end

endmodule
